// ----- rtl/core/rxs_pkg.sv -----
// Package for the rolling XOR frame scrambler.
// Holds the request and result types, the frame constants and the key table.
// Depends on nothing.
package rxs_pkg;

  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned KEY_LEN      = 9;

  localparam int unsigned HDR_W   = 4;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned BYTE_W  = 8;

  typedef struct packed {
    logic              frame_start;
    logic [BYTE_W-1:0] data_byte;
  } plain_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              in_body;
  } scr_res_t;

  function automatic logic [BYTE_W-1:0] key_byte(input logic [PHASE_W-1:0] phase);
    logic [BYTE_W-1:0] k;
    unique case (phase)
      4'd0:    k = 8'h4B;
      4'd1:    k = 8'h0D;
      4'd2:    k = 8'hEF;
      4'd3:    k = 8'h60;
      4'd4:    k = 8'hC9;
      4'd5:    k = 8'h9A;
      4'd6:    k = 8'h70;
      4'd7:    k = 8'h0E;
      4'd8:    k = 8'h03;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/rolling_xor_frame_scrambler.sv -----
// Top level of the rolling XOR frame scrambler: request port, result register.
// Depends on rxs_pkg and rxs_core.
//
//   Channel   Signals                               Carries
//   plain     plain_valid, plain_ready, plain       frame_start, data_byte
//   scr       scr_valid, scr_ready, scr             out_byte, in_body
//
// The result is computed from the request and the frame state and is registered
// on the edge that accepts the request.
// One request is accepted every cycle while the result register is empty or drained.
// A stalled result holds the register and stops further requests.
// Reset clears the frame state and empties the result register.
module rolling_xor_frame_scrambler (
  input  logic                clk,
  input  logic                rst,
  input  logic                plain_valid,
  output logic                plain_ready,
  input  rxs_pkg::plain_req_t plain,
  output logic                scr_valid,
  input  logic                scr_ready,
  output rxs_pkg::scr_res_t   scr
);

  logic              accept;
  rxs_pkg::scr_res_t res;

  assign plain_ready = !scr_valid || scr_ready;
  assign accept      = plain_valid && plain_ready;

  rxs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (plain),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_valid <= 1'b0;
    end else if (plain_ready) begin
      scr_valid <= plain_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scr <= res;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> scr_valid)
    else $error("accepted request did not produce a result");

  a_start_is_header: assert property (@(posedge clk) disable iff (rst)
    (accept && plain.frame_start) |=> !scr.in_body)
    else $error("first byte of a frame was scrambled");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (scr_valid && !scr_ready) |-> !plain_ready)
    else $error("request taken while result stalled");
`endif

endmodule

// ----- rtl/core/rxs_core.sv -----
// Frame state and scrambling logic of the rolling XOR frame scrambler.
// Holds the header count, key phase, body index and feedback byte.
// Depends on rxs_pkg.
module rxs_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  rxs_pkg::plain_req_t req,
  output rxs_pkg::scr_res_t   res
);

  logic [rxs_pkg::HDR_W-1:0]   header_count, header_count_next;
  logic [rxs_pkg::PHASE_W-1:0] key_phase, key_phase_next;
  logic [rxs_pkg::BYTE_W-1:0]  body_index, body_index_next;
  logic [rxs_pkg::BYTE_W-1:0]  feedback, feedback_next;

  logic [rxs_pkg::HDR_W-1:0]   hdr_cur;
  logic [rxs_pkg::PHASE_W-1:0] phase_cur;
  logic [rxs_pkg::BYTE_W-1:0]  index_cur;
  logic [rxs_pkg::BYTE_W-1:0]  fb_cur;
  logic [rxs_pkg::BYTE_W-1:0]  product;
  logic                        body;

  // A start flag makes the byte see the state of a fresh frame.
  always_comb begin
    hdr_cur   = req.frame_start ? '0 : header_count;
    phase_cur = req.frame_start ? '0 : key_phase;
    index_cur = req.frame_start ? '0 : body_index;
    fb_cur    = req.frame_start ? '0 : feedback;
    body      = ({1'b0, hdr_cur} >= (rxs_pkg::HDR_W+1)'(rxs_pkg::HEADER_BYTES));
    product   = req.data_byte * index_cur;

    header_count_next = hdr_cur;
    key_phase_next    = phase_cur;
    body_index_next   = index_cur;
    feedback_next     = fb_cur;

    if (body) begin
      res.out_byte    = req.data_byte ^ rxs_pkg::key_byte(phase_cur) ^ fb_cur;
      res.in_body     = 1'b1;
      feedback_next   = product + {fb_cur[rxs_pkg::BYTE_W-2:0], 1'b0};
      body_index_next = index_cur + 1'b1;
      if (phase_cur == rxs_pkg::PHASE_W'(rxs_pkg::KEY_LEN - 1)) begin
        key_phase_next = '0;
      end else begin
        key_phase_next = phase_cur + 1'b1;
      end
    end else begin
      res.out_byte      = req.data_byte;
      res.in_body       = 1'b0;
      header_count_next = hdr_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      key_phase    <= '0;
      body_index   <= '0;
      feedback     <= '0;
    end else if (accept) begin
      header_count <= header_count_next;
      key_phase    <= key_phase_next;
      body_index   <= body_index_next;
      feedback     <= feedback_next;
    end
  end

endmodule
